// ===== rtl/tkos_pkg.sv =====
// Shared types for the order-preserving top-k selector.
// Holds the controller command and status bundles; no dependencies.
`default_nettype none
package tkos_pkg;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // store the accepted beat and count it
		logic prep;     // latch clamped keep count, clear selection state
		logic scan;     // issue a read and rank the returned entry
		logic mark;     // mark the best entry of the finished pass
		logic emit_rd;  // issue a read for the next position
		logic emit_cap; // capture the returned entry into the output register
		logic emit_adv; // output beat taken: count it
		logic finish;   // empty the set
	} tkos_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic k_zero;     // nothing to select
		logic scan_done;  // all reads of a pass issued and returned
		logic pass_last;  // the pass being marked is the final one
		logic pos_chosen; // returned entry belongs to the selection
		logic out_last;   // output register holds the final result
	} tkos_stat_t;

endpackage
`default_nettype wire

// ===== rtl/tkos_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module tkos_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/tkos_ctrl.sv =====
// Controller state machine for the order-preserving top-k selector.
// Depends on tkos_pkg for the command and status bundles.
`default_nettype none
module tkos_ctrl
	import tkos_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_acc,
	input  wire logic       in_last,
	input  wire logic       out_rdy,
	input  tkos_stat_t      stat,
	output tkos_cmd_t       cmd,
	output logic            in_rdy,
	output logic            out_vld
);

	typedef enum logic [6:0] {
		S_LOAD     = 7'b0000001,
		S_PREP     = 7'b0000010,
		S_SCAN     = 7'b0000100,
		S_MARK     = 7'b0001000,
		S_EMIT_RD  = 7'b0010000,
		S_EMIT_CHK = 7'b0100000,
		S_EMIT_OUT = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign in_rdy  = (state_q == S_LOAD);
	assign out_vld = (state_q == S_EMIT_OUT);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_LOAD: begin
				cmd.load = in_acc;
				if (in_acc && in_last) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				if (stat.k_zero) begin
					cmd.finish = 1'b1;
					state_d    = S_LOAD;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					state_d = S_MARK;
				end
			end
			S_MARK: begin
				cmd.mark = 1'b1;
				state_d  = stat.pass_last ? S_EMIT_RD : S_SCAN;
			end
			S_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = S_EMIT_CHK;
			end
			S_EMIT_CHK: begin
				cmd.emit_cap = stat.pos_chosen;
				state_d      = stat.pos_chosen ? S_EMIT_OUT : S_EMIT_RD;
			end
			S_EMIT_OUT: begin
				if (out_rdy) begin
					cmd.emit_adv = 1'b1;
					if (stat.out_last) begin
						cmd.finish = 1'b1;
						state_d    = S_LOAD;
					end else begin
						state_d = S_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tkos_dp.sv =====
// Datapath for the order-preserving top-k selector: value store, counters,
// ranking compare, selection flags and output register. Uses tkos_pkg, tkos_ram.
`default_nettype none
module tkos_dp
	import tkos_pkg::*;
#(
	parameter int MAX_ITEMS   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  tkos_cmd_t        cmd,
	output tkos_stat_t       stat,
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_wdata,
	input  wire logic [31:0] in_value,
	output logic      [31:0] out_value,
	output logic      [5:0]  out_pos,
	output logic             out_last
);

	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	logic [6:0]             keep_q;
	logic [CNT_W-1:0]       count_q, kc_q, pass_q, emit_cnt_q, addr_q;
	logic [CNT_W-1:0]       kc_d;
	logic [IDX_W-1:0]       best_pos_q, pos_s1;
	logic [VALUE_WIDTH-1:0] best_val_q, rdata, wdata;
	logic                   best_ok_q, rd_v_s1;
	logic [MAX_ITEMS-1:0]   chosen_q;
	logic [63:0]            in_ext;
	logic signed [63:0]     rd_ext;
	logic                   rd_issue, better;

	// Take the low bits of the beat; widen with zeros if the store is wider
	assign in_ext = 64'(in_value);
	assign wdata  = in_ext[VALUE_WIDTH-1:0];
	assign rd_ext = 64'($signed(rdata));

	tkos_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ITEMS)) u_store (
		.clk   (clk),
		.we    (cmd.load && (count_q < CNT_W'(MAX_ITEMS))),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wdata),
		.raddr (addr_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	// Clamp keep count to the loaded set size
	assign kc_d     = (keep_q > 7'(count_q)) ? count_q : CNT_W'(keep_q);
	assign rd_issue = cmd.scan && (addr_q != count_q);
	// Earlier position wins ties: only a strictly larger value replaces
	assign better   = rd_v_s1 && !chosen_q[pos_s1] &&
	                  (!best_ok_q || ($signed(rdata) > $signed(best_val_q)));

	assign stat.k_zero     = (kc_d == '0);
	assign stat.scan_done  = (addr_q == count_q) && !rd_v_s1;
	assign stat.pass_last  = (CNT_W'(pass_q + 1'b1) == kc_q);
	assign stat.pos_chosen = chosen_q[pos_s1];
	assign stat.out_last   = out_last;

	// Control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q     <= 7'd1;
			count_q    <= '0;
			kc_q       <= '0;
			pass_q     <= '0;
			emit_cnt_q <= '0;
			addr_q     <= '0;
			best_ok_q  <= 1'b0;
			rd_v_s1    <= 1'b0;
			chosen_q   <= '0;
		end else begin
			if (cfg_we) begin
				keep_q <= cfg_wdata;
			end
			if (cmd.load && (count_q < CNT_W'(MAX_ITEMS))) begin
				count_q <= count_q + 1'b1;
			end
			rd_v_s1 <= rd_issue;
			if (cmd.prep) begin
				kc_q       <= kc_d;
				pass_q     <= '0;
				emit_cnt_q <= '0;
				addr_q     <= '0;
				best_ok_q  <= 1'b0;
				chosen_q   <= '0;
			end
			if (rd_issue || cmd.emit_rd) begin
				addr_q <= addr_q + 1'b1;
			end
			if (better) begin
				best_ok_q <= 1'b1;
			end
			if (cmd.mark) begin
				chosen_q[best_pos_q] <= 1'b1;
				pass_q               <= pass_q + 1'b1;
				addr_q               <= '0;
				best_ok_q            <= 1'b0;
			end
			if (cmd.emit_adv) begin
				emit_cnt_q <= emit_cnt_q + 1'b1;
			end
			if (cmd.finish) begin
				count_q <= '0;
			end
		end
	end

	// Payload registers: read position, running best, output beat
	always_ff @(posedge clk) begin
		if (rd_issue || cmd.emit_rd) begin
			pos_s1 <= addr_q[IDX_W-1:0];
		end
		if (better) begin
			best_val_q <= rdata;
			best_pos_q <= pos_s1;
		end
		if (cmd.emit_cap) begin
			out_value <= rd_ext[31:0];
			out_pos   <= 6'(pos_s1);
			out_last  <= (CNT_W'(emit_cnt_q + 1'b1) == kc_q);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/top_k_order_preserving_select.sv =====
// Order-preserving top-k selector: top level joining controller and datapath.
// Depends on tkos_pkg, tkos_ctrl, tkos_dp (which holds tkos_ram).
//
// Values load one beat per cycle into a MAX_ITEMS-entry store; a beat with
// s_tlast closes the set (values beyond MAX_ITEMS are dropped). Selection then
// runs one ranking pass per kept value, k passes with k the keep count clamped
// to the n loaded values, each pass reading the store once per entry through
// its single read port. Results then leave in arrival order, the last one with
// m_tlast; emission reads the stored positions in order and holds each chosen
// one on the output until m_tready takes it. No beat is taken while a set is
// being selected or emitted. A keep count of zero ends the set with no result.
// keep_count resets to 1 and is written via cfg_we.
`default_nettype none
module top_k_order_preserving_select
	import tkos_pkg::*;
#(
	parameter int MAX_ITEMS   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] sample_value
	input  wire logic        s_tlast,   // final_item
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // [31:0] chosen_value, [37:32] chosen_position
	output logic             m_tlast,   // run_end
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_wdata  // keep_count
);

	tkos_cmd_t   cmd;
	tkos_stat_t  stat;
	logic [31:0] out_value;
	logic [5:0]  out_pos;

	tkos_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_acc  (s_tvalid && s_tready),
		.in_last (s_tlast),
		.out_rdy (m_tready),
		.stat    (stat),
		.cmd     (cmd),
		.in_rdy  (s_tready),
		.out_vld (m_tvalid)
	);

	tkos_dp #(.MAX_ITEMS(MAX_ITEMS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_value  (s_tdata),
		.out_value (out_value),
		.out_pos   (out_pos),
		.out_last  (m_tlast)
	);

	// Pack the output beat
	assign m_tdata = {2'b00, out_pos, out_value};

endmodule
`default_nettype wire

// ===== verif/top_k_order_preserving_select_test.sv =====
// Testbench for the order-preserving top-k selector.
// Depends on tkos_pkg and top_k_order_preserving_select; self-checking, no files.
`timescale 1ns / 1ps
`default_nettype none
module top_k_order_preserving_select_test;
	import tkos_pkg::*;

	localparam int MAX_ITEMS = 64;

	typedef struct packed {
		logic signed [31:0] value;
		logic [5:0]         position;
		logic               run_end;
	} pick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;

	// predictor state
	logic signed [31:0] set_values [MAX_ITEMS];
	int unsigned set_len = 0;
	logic [6:0] keep_now = 7'd1;
	pick_t picks_due [$];

	int errors = 0;
	int results_seen = 0;
	int sets_closed = 0;
	bit sink_idle_on = 1'b1;
	bit src_idle_on = 1'b1;
	int sink_hold = 0;

	top_k_order_preserving_select DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Store one value; on the final one rank the set and queue the picks
	task automatic predict_picks(input logic signed [31:0] v, input bit fin);
		int unsigned n, k, rank, got;
		bit taken [MAX_ITEMS];
		pick_t p;
		if (set_len < MAX_ITEMS) begin
			set_values[set_len] = v;
			set_len++;
		end
		if (!fin)
			return;
		n = set_len;
		k = (keep_now > n) ? n : keep_now;
		for (int i = 0; i < n; i++) begin
			rank = 0;
			for (int j = 0; j < n; j++)
				if (j != i && (set_values[j] > set_values[i] ||
						(set_values[j] == set_values[i] && j < i)))
					rank++;
			taken[i] = rank < k;
		end
		got = 0;
		for (int i = 0; i < n; i++) begin
			if (taken[i]) begin
				got++;
				p.value = set_values[i];
				p.position = i[5:0];
				p.run_end = (got == k);
				picks_due = {picks_due, p};
			end
		end
		set_len = 0;
		sets_closed++;
	endtask

	// Offer one beat until taken; valid stays up for the next beat
	task automatic send_sample(input logic signed [31:0] v, input bit fin);
		while (src_idle_on && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_picks(v, fin);
	endtask

	task automatic drain_picks();
		s_tvalid <= 1'b0;
		while (picks_due.size() != 0)
			@(posedge clk);
		// selection of an empty result set may still be running
		repeat (200) @(posedge clk);
	endtask

	task automatic write_keep(input logic [6:0] k);
		drain_picks();
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		keep_now = k;
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(7)) - 3;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_set(input int len);
		for (int i = 0; i < len; i++)
			send_sample(rand_value(), i == len - 1);
	endtask

	// Extremes, ties, zero and oversized keep count
	task automatic test_directed();
		send_sample(32'sh7fffffff, 1'b0);
		send_sample(32'sh80000000, 1'b0);
		send_sample(32'sh7fffffff, 1'b1);
		write_keep(7'd3);
		send_sample(5, 1'b0);
		send_sample(5, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(5, 1'b0);
		send_sample(0, 1'b1);
		write_keep(7'd0);
		send_sample(9, 1'b0);
		send_sample(-9, 1'b1);
		write_keep(7'd127);
		send_sample(32'shffffffff, 1'b0);
		send_sample(32'sh55555555, 1'b0);
		send_sample(32'shaaaaaaaa, 1'b1);
		send_sample(42, 1'b1);
	endtask

	// Overflow the store: values past the limit are dropped
	task automatic test_overflow();
		write_keep(7'd64);
		send_set(MAX_ITEMS + 3);
	endtask

	task automatic test_random();
		logic [6:0] ks [5] = '{7'd2, 7'd5, 7'd1, 7'd64, 7'd8};
		for (int s = 0; s < 5; s++) begin
			write_keep(ks[s]);
			send_set($urandom_range(1, 4));
		end
	endtask

	// Hold the output off while offering sets, wait for everything, then send a set with the output always ready
	task automatic test_backpressure();
		write_keep(7'd2);
		src_idle_on = 1'b0;
		sink_hold = 300;
		send_set(4);
		send_set(3);
		drain_picks();
		src_idle_on = 1'b1;
		sink_idle_on = 1'b0;
		send_set(5);
		sink_idle_on = 1'b1;
	endtask

	// Output ready: long hold-off when asked, else random idling
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(sink_idle_on && $urandom_range(99) < 11);
		end
	end

	// Compare each result beat with the oldest pick due
	always @(posedge clk) begin
		pick_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (picks_due.size() == 0) begin
				$error("result beat with none expected: %h", m_tdata);
				errors++;
			end else begin
				want = picks_due.pop_front();
				if ($signed(m_tdata[31:0]) !== want.value) begin
					$error("chosen_value expected %0d actual %0d", want.value,
						$signed(m_tdata[31:0]));
					errors++;
				end
				if (m_tdata[37:32] !== want.position) begin
					$error("chosen_position expected %0d actual %0d", want.position,
						m_tdata[37:32]);
					errors++;
				end
				if (m_tlast !== want.run_end) begin
					$error("run_end expected %0d actual %0d", want.run_end, m_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_random();
		test_backpressure();
		drain_picks();
		$display("Closed %0d sets and checked %0d result beats", sets_closed, results_seen);
		$display("keep counts from 0 to 127 tried, with overflow, ties and stalls");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire

// ===== top_k_order_preserving_select.f =====
rtl/tkos_pkg.sv
rtl/tkos_ram.sv
rtl/tkos_ctrl.sv
rtl/tkos_dp.sv
rtl/top_k_order_preserving_select.sv
verif/top_k_order_preserving_select_test.sv
